// File: sv/pm0_pkg.sv
package pm0_pkg;

    localparam int MEM_WORDS  = 512;
    localparam int ADDR_W     = $clog2(MEM_WORDS);
    localparam int DATA_W     = 32;
    localparam int PC_W       = 10;
    localparam int LEV_W      = 3;
    localparam int MAX_LEVELS = 7;
    localparam int NINS_W     = 8;

    // opcodes
    localparam logic [3:0] FN_LIT = 4'd1;
    localparam logic [3:0] FN_OPR = 4'd2;
    localparam logic [3:0] FN_LOD = 4'd3;
    localparam logic [3:0] FN_STO = 4'd4;
    localparam logic [3:0] FN_CAL = 4'd5;
    localparam logic [3:0] FN_INC = 4'd6;
    localparam logic [3:0] FN_JMP = 4'd7;
    localparam logic [3:0] FN_JPC = 4'd8;
    localparam logic [3:0] FN_SYS = 4'd9;

    // OPR selectors
    localparam logic [15:0] OPR_RET  = 16'd0;
    localparam logic [15:0] OPR_ADD  = 16'd1;
    localparam logic [15:0] OPR_SUB  = 16'd2;
    localparam logic [15:0] OPR_MUL  = 16'd3;
    localparam logic [15:0] OPR_DIV  = 16'd4;
    localparam logic [15:0] OPR_EQL  = 16'd5;
    localparam logic [15:0] OPR_NEQ  = 16'd6;
    localparam logic [15:0] OPR_LSS  = 16'd7;
    localparam logic [15:0] OPR_LEQ  = 16'd8;
    localparam logic [15:0] OPR_GTR  = 16'd9;
    localparam logic [15:0] OPR_GEQ  = 16'd10;
    localparam logic [15:0] OPR_EVEN = 16'd11;

    // SYS selectors
    localparam logic [15:0] SYS_OUT  = 16'd1;
    localparam logic [15:0] SYS_IN   = 16'd2;
    localparam logic [15:0] SYS_HALT = 16'd3;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_RD_TOP, S_RD_NXT, S_DECODE, S_WALK_RD, S_WALK_CAP,
        S_LOD_RD, S_LOD_CAP, S_RET_A, S_RET_B, S_RET_C, S_DIV_GO, S_DIV_WAIT,
        S_EXEC, S_CAL2, S_CAL3, S_RESP
    } state_t;

    typedef enum logic [2:0] {
        RD_SP, RD_SP1, RD_X, RD_LOD, RD_BPM1, RD_BPM2
    } rd_sel_t;

    typedef struct packed {
        logic    clr_we;
        logic    take_in;
        rd_sel_t rd_sel;
        logic    cap_top;
        logic    cap_nxt;
        logic    walk_dec;
        logic    cap_x;
        logic    cap_ld;
        logic    div_start;
        logic    commit;
        logic    cal2;
        logic    cal3;
    } pm0_cmd_t;

    typedef struct packed {
        logic [3:0]  func;
        logic [15:0] m;
        logic        walk_zero;
        logic        top_zero;
        logic        div_done;
        logic        halted;
        logic        clear_last;
    } pm0_status_t;

    // stack pointer after a restart for n loaded instructions
    function automatic logic [ADDR_W-1:0] init_sp(logic [NINS_W-1:0] n);
        logic [NINS_W+1:0] t3;
        t3 = (NINS_W+2)'(n) * (NINS_W+2)'(3);
        return ADDR_W'(0) - ADDR_W'(t3);
    endfunction

endpackage

// File: sv/pm0_in_if.sv
interface pm0_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         func;
    logic [2:0]         lev;
    logic [15:0]        m;
    logic signed [31:0] read_value;

    modport source(output valid, func, lev, m, read_value, input ready);
    modport sink(input valid, func, lev, m, read_value, output ready);
endinterface

// File: sv/pm0_out_if.sv
interface pm0_out_if;
    logic               valid;
    logic               ready;
    logic [9:0]         next_pc;
    logic               out_valid;
    logic signed [31:0] out_value;
    logic               halted;
    logic               fault;
    logic [8:0]         stack_pointer;
    logic [8:0]         frame_base;

    modport source(output valid, next_pc, out_valid, out_value, halted, fault,
                   stack_pointer, frame_base, input ready);
    modport sink(input valid, next_pc, out_valid, out_value, halted, fault,
                 stack_pointer, frame_base, output ready);
endinterface

// File: sv/pm0_div.sv
module pm0_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pm0_pkg::DATA_W-1:0] dividend,
    input  logic [pm0_pkg::DATA_W-1:0] divisor,
    output logic                       done,
    output logic [pm0_pkg::DATA_W-1:0] quotient
);
    localparam int W   = pm0_pkg::DATA_W;
    localparam int CW  = $clog2(W + 1);

    logic [W:0]    rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          neg_reg, neg_next;
    logic          done_reg, done_next;
    logic [W:0]    shifted;
    logic [W:0]    diff;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[W-1:0], quo_reg[W-1]};
        diff      = shifted - {1'b0, dsr_reg};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend[W-1] ? (W'(0) - dividend) : dividend;
            dsr_next  = divisor[W-1] ? (W'(0) - divisor) : divisor;
            neg_next  = dividend[W-1] ^ divisor[W-1];
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_next = diff;
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (W'(0) - quo_reg) : quo_reg;
endmodule

// File: sv/pm0_datapath.sv
module pm0_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pm0_pkg::pm0_cmd_t           cmd,
    output pm0_pkg::pm0_status_t        status,
    input  logic [3:0]                  func,
    input  logic [2:0]                  lev,
    input  logic [15:0]                 m,
    input  logic [31:0]                 read_value,
    input  logic                        cfg_we,
    input  logic [pm0_pkg::NINS_W-1:0]  cfg_wdata,
    output logic [9:0]                  next_pc,
    output logic                        out_valid,
    output logic [31:0]                 out_value,
    output logic                        halted,
    output logic                        fault,
    output logic [8:0]                  stack_pointer,
    output logic [8:0]                  frame_base
);
    localparam int A  = pm0_pkg::ADDR_W;
    localparam int D  = pm0_pkg::DATA_W;
    localparam int P  = pm0_pkg::PC_W;
    localparam int LW = pm0_pkg::LEV_W;

    logic [D-1:0]  mem [pm0_pkg::MEM_WORDS];
    logic [D-1:0]  rdata_reg;
    logic [A-1:0]  raddr;
    logic          we;
    logic [A-1:0]  waddr;
    logic [D-1:0]  wdata;

    logic [A-1:0]  sp_reg, sp_next, bp_reg, bp_next, x_reg, x_next;
    logic [P-1:0]  pc_reg, pc_next;
    logic          halt_reg, halt_next;
    logic [A-1:0]  clr_reg;
    logic [LW-1:0] cnt_reg, cnt_next;
    logic [D-1:0]  top_reg, nxt_reg, ld_reg;
    logic [3:0]    func_reg;
    logic [15:0]   m_reg;
    logic [D-1:0]  rv_reg;
    logic [D-1:0]  ov_reg, ov_next;
    logic          valid_reg, valid_next, fault_reg, fault_next;
    logic [LW-1:0] lev_sat;
    logic [P-1:0]  pc_inc;
    logic [D-1:0]  alu;
    logic          div_done;
    logic [D-1:0]  quotient;

    pm0_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .dividend(nxt_reg),
        .divisor (top_reg),
        .done    (div_done),
        .quotient(quotient)
    );

    assign lev_sat = (lev > LW'(pm0_pkg::MAX_LEVELS)) ? LW'(pm0_pkg::MAX_LEVELS) : lev;
    assign pc_inc  = pc_reg + P'(1);

    // select read address
    always_comb
    begin
        case (cmd.rd_sel)
            pm0_pkg::RD_SP:   raddr = sp_reg;
            pm0_pkg::RD_SP1:  raddr = sp_reg + A'(1);
            pm0_pkg::RD_X:    raddr = x_reg;
            pm0_pkg::RD_LOD:  raddr = x_reg - m_reg[A-1:0];
            pm0_pkg::RD_BPM1: raddr = bp_reg - A'(1);
            pm0_pkg::RD_BPM2: raddr = bp_reg - A'(2);
            default:          raddr = sp_reg;
        endcase
    end

    // arithmetic and compare on the two top words
    always_comb
    begin
        case (m_reg)
            pm0_pkg::OPR_ADD: alu = nxt_reg + top_reg;
            pm0_pkg::OPR_SUB: alu = nxt_reg - top_reg;
            pm0_pkg::OPR_MUL: alu = nxt_reg * top_reg;
            pm0_pkg::OPR_DIV: alu = (top_reg == '0) ? '0 : quotient;
            pm0_pkg::OPR_EQL: alu = D'(nxt_reg == top_reg);
            pm0_pkg::OPR_NEQ: alu = D'(nxt_reg != top_reg);
            pm0_pkg::OPR_LSS: alu = D'($signed(nxt_reg) <  $signed(top_reg));
            pm0_pkg::OPR_LEQ: alu = D'($signed(nxt_reg) <= $signed(top_reg));
            pm0_pkg::OPR_GTR: alu = D'($signed(nxt_reg) >  $signed(top_reg));
            default:          alu = D'($signed(nxt_reg) >= $signed(top_reg));
        endcase
    end

    // execute: store writes and pointer, pc, output and halt updates
    always_comb
    begin
        sp_next    = sp_reg;
        bp_next    = bp_reg;
        pc_next    = pc_reg;
        halt_next  = halt_reg;
        x_next     = x_reg;
        cnt_next   = cnt_reg;
        ov_next    = ov_reg;
        valid_next = valid_reg;
        fault_next = fault_reg;
        we         = 1'b0;
        waddr      = sp_reg;
        wdata      = '0;
        if (cmd.clr_we)
        begin
            we    = 1'b1;
            waddr = clr_reg;
        end
        if (cmd.take_in)
        begin
            ov_next    = '0;
            valid_next = 1'b0;
            fault_next = 1'b0;
            x_next     = bp_reg;
            cnt_next   = lev_sat;
        end
        if (cmd.walk_dec)
            cnt_next = cnt_reg - LW'(1);
        if (cmd.cap_x)
            x_next = rdata_reg[A-1:0];
        if (cmd.commit)
        begin
            pc_next = pc_inc;
            case (func_reg)
                pm0_pkg::FN_LIT:
                begin
                    we      = 1'b1;
                    waddr   = sp_reg - A'(1);
                    wdata   = D'(m_reg);
                    sp_next = sp_reg - A'(1);
                end
                pm0_pkg::FN_OPR:
                begin
                    if (m_reg == pm0_pkg::OPR_RET)
                    begin
                        sp_next = bp_reg + A'(1);
                        bp_next = x_reg;
                        pc_next = ld_reg[P-1:0];
                    end
                    else if (m_reg <= pm0_pkg::OPR_GEQ)
                    begin
                        we      = 1'b1;
                        waddr   = sp_reg + A'(1);
                        wdata   = alu;
                        sp_next = sp_reg + A'(1);
                        fault_next = (m_reg == pm0_pkg::OPR_DIV) && (top_reg == '0);
                    end
                    else if (m_reg == pm0_pkg::OPR_EVEN)
                    begin
                        we    = 1'b1;
                        waddr = sp_reg;
                        wdata = D'(!top_reg[0]);
                    end
                end
                pm0_pkg::FN_LOD:
                begin
                    we      = 1'b1;
                    waddr   = sp_reg - A'(1);
                    wdata   = ld_reg;
                    sp_next = sp_reg - A'(1);
                end
                pm0_pkg::FN_STO:
                begin
                    we      = 1'b1;
                    waddr   = x_reg - m_reg[A-1:0];
                    wdata   = top_reg;
                    sp_next = sp_reg + A'(1);
                end
                pm0_pkg::FN_CAL:
                begin
                    // static link first; pc moves with the last frame word
                    we      = 1'b1;
                    waddr   = sp_reg - A'(1);
                    wdata   = D'(x_reg);
                    pc_next = pc_reg;
                end
                pm0_pkg::FN_INC:
                    sp_next = sp_reg - m_reg[A-1:0];
                pm0_pkg::FN_JMP:
                    pc_next = m_reg[P-1:0];
                pm0_pkg::FN_JPC:
                begin
                    if (top_reg == '0)
                        pc_next = m_reg[P-1:0];
                    sp_next = sp_reg + A'(1);
                end
                pm0_pkg::FN_SYS:
                begin
                    if (m_reg == pm0_pkg::SYS_OUT)
                    begin
                        ov_next    = top_reg;
                        valid_next = 1'b1;
                        sp_next    = sp_reg + A'(1);
                    end
                    else if (m_reg == pm0_pkg::SYS_IN)
                    begin
                        we      = 1'b1;
                        waddr   = sp_reg - A'(1);
                        wdata   = rv_reg;
                        sp_next = sp_reg - A'(1);
                    end
                    else if (m_reg == pm0_pkg::SYS_HALT)
                        halt_next = 1'b1;
                end
                default: ;
            endcase
        end
        if (cmd.cal2)
        begin
            we    = 1'b1;
            waddr = sp_reg - A'(2);
            wdata = D'(bp_reg);
        end
        if (cmd.cal3)
        begin
            we      = 1'b1;
            waddr   = sp_reg - A'(3);
            wdata   = D'(pc_inc);
            bp_next = sp_reg - A'(1);
            pc_next = m_reg[P-1:0];
        end
        // restart on a register write
        if (cfg_we)
        begin
            sp_next   = pm0_pkg::init_sp(cfg_wdata);
            bp_next   = pm0_pkg::init_sp(cfg_wdata) - A'(1);
            pc_next   = '0;
            halt_next = 1'b0;
        end
    end

    // data store
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg    <= pm0_pkg::init_sp(pm0_pkg::NINS_W'(1));
            bp_reg    <= pm0_pkg::init_sp(pm0_pkg::NINS_W'(1)) - A'(1);
            pc_reg    <= '0;
            halt_reg  <= 1'b0;
            clr_reg   <= '0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
            fault_reg <= 1'b0;
        end
        else
        begin
            sp_reg    <= sp_next;
            bp_reg    <= bp_next;
            pc_reg    <= pc_next;
            halt_reg  <= halt_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
            fault_reg <= fault_next;
            if (cmd.clr_we)
                clr_reg <= clr_reg + A'(1);
        end
    end

    // hold operands and the latched item
    always_ff @(posedge clk)
    begin
        x_reg  <= x_next;
        ov_reg <= ov_next;
        if (cmd.take_in)
        begin
            func_reg <= func;
            m_reg    <= m;
            rv_reg   <= read_value;
        end
        if (cmd.cap_top)
            top_reg <= rdata_reg;
        if (cmd.cap_nxt)
            nxt_reg <= rdata_reg;
        if (cmd.cap_ld)
            ld_reg <= rdata_reg;
    end

    assign status.func       = func_reg;
    assign status.m          = m_reg;
    assign status.walk_zero  = (cnt_reg == '0);
    assign status.top_zero   = (top_reg == '0);
    assign status.div_done   = div_done;
    assign status.halted     = halt_reg;
    assign status.clear_last = (clr_reg == A'(pm0_pkg::MEM_WORDS - 1));

    assign next_pc       = pc_reg;
    assign out_valid     = valid_reg;
    assign out_value     = ov_reg;
    assign halted        = halt_reg;
    assign fault         = fault_reg;
    assign stack_pointer = sp_reg;
    assign frame_base    = bp_reg;
endmodule

// File: sv/pm0_ctrl.sv
module pm0_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 out_ready,
    input  pm0_pkg::pm0_status_t status,
    output pm0_pkg::pm0_cmd_t    cmd,
    output logic                 in_ready,
    output logic                 res_valid
);
    pm0_pkg::state_t state_reg, state_next;
    logic            is_walk;
    pm0_pkg::state_t after_walk;

    assign is_walk = (status.func == pm0_pkg::FN_LOD) || (status.func == pm0_pkg::FN_STO) ||
                     (status.func == pm0_pkg::FN_CAL);
    assign after_walk = (status.func == pm0_pkg::FN_LOD) ? pm0_pkg::S_LOD_RD
                                                         : pm0_pkg::S_EXEC;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pm0_pkg::S_CLEAR:
                if (status.clear_last)
                    state_next = pm0_pkg::S_IDLE;
            pm0_pkg::S_IDLE:
                if (in_valid)
                    state_next = status.halted ? pm0_pkg::S_RESP : pm0_pkg::S_RD_TOP;
            pm0_pkg::S_RD_TOP:
                state_next = pm0_pkg::S_RD_NXT;
            pm0_pkg::S_RD_NXT:
                state_next = pm0_pkg::S_DECODE;
            pm0_pkg::S_DECODE:
            begin
                if (is_walk)
                    state_next = status.walk_zero ? after_walk : pm0_pkg::S_WALK_RD;
                else if (status.func == pm0_pkg::FN_OPR && status.m == pm0_pkg::OPR_RET)
                    state_next = pm0_pkg::S_RET_A;
                else if (status.func == pm0_pkg::FN_OPR && status.m == pm0_pkg::OPR_DIV &&
                         !status.top_zero)
                    state_next = pm0_pkg::S_DIV_GO;
                else
                    state_next = pm0_pkg::S_EXEC;
            end
            pm0_pkg::S_WALK_RD:
                state_next = pm0_pkg::S_WALK_CAP;
            pm0_pkg::S_WALK_CAP:
                state_next = status.walk_zero ? after_walk : pm0_pkg::S_WALK_RD;
            pm0_pkg::S_LOD_RD:
                state_next = pm0_pkg::S_LOD_CAP;
            pm0_pkg::S_LOD_CAP:
                state_next = pm0_pkg::S_EXEC;
            pm0_pkg::S_RET_A:
                state_next = pm0_pkg::S_RET_B;
            pm0_pkg::S_RET_B:
                state_next = pm0_pkg::S_RET_C;
            pm0_pkg::S_RET_C:
                state_next = pm0_pkg::S_EXEC;
            pm0_pkg::S_DIV_GO:
                state_next = pm0_pkg::S_DIV_WAIT;
            pm0_pkg::S_DIV_WAIT:
                if (status.div_done)
                    state_next = pm0_pkg::S_EXEC;
            pm0_pkg::S_EXEC:
                state_next = (status.func == pm0_pkg::FN_CAL) ? pm0_pkg::S_CAL2
                                                              : pm0_pkg::S_RESP;
            pm0_pkg::S_CAL2:
                state_next = pm0_pkg::S_CAL3;
            pm0_pkg::S_CAL3:
                state_next = pm0_pkg::S_RESP;
            pm0_pkg::S_RESP:
                if (out_ready)
                    state_next = pm0_pkg::S_IDLE;
            default:
                state_next = pm0_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd       = '0;
        cmd.rd_sel = pm0_pkg::RD_SP;
        in_ready  = 1'b0;
        res_valid = 1'b0;
        unique case (state_reg)
            pm0_pkg::S_CLEAR:    cmd.clr_we = 1'b1;
            pm0_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.take_in = in_valid;
            end
            pm0_pkg::S_RD_TOP:   cmd.rd_sel = pm0_pkg::RD_SP;
            pm0_pkg::S_RD_NXT:
            begin
                cmd.rd_sel  = pm0_pkg::RD_SP1;
                cmd.cap_top = 1'b1;
            end
            pm0_pkg::S_DECODE:   cmd.cap_nxt = 1'b1;
            pm0_pkg::S_WALK_RD:
            begin
                cmd.rd_sel   = pm0_pkg::RD_X;
                cmd.walk_dec = 1'b1;
            end
            pm0_pkg::S_WALK_CAP: cmd.cap_x = 1'b1;
            pm0_pkg::S_LOD_RD:   cmd.rd_sel = pm0_pkg::RD_LOD;
            pm0_pkg::S_LOD_CAP:  cmd.cap_ld = 1'b1;
            pm0_pkg::S_RET_A:    cmd.rd_sel = pm0_pkg::RD_BPM1;
            pm0_pkg::S_RET_B:
            begin
                cmd.rd_sel = pm0_pkg::RD_BPM2;
                cmd.cap_x  = 1'b1;
            end
            pm0_pkg::S_RET_C:    cmd.cap_ld = 1'b1;
            pm0_pkg::S_DIV_GO:   cmd.div_start = 1'b1;
            pm0_pkg::S_DIV_WAIT: ;
            pm0_pkg::S_EXEC:     cmd.commit = 1'b1;
            pm0_pkg::S_CAL2:     cmd.cal2 = 1'b1;
            pm0_pkg::S_CAL3:     cmd.cal3 = 1'b1;
            pm0_pkg::S_RESP:     res_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pm0_pkg::S_CLEAR;
        else
            state_reg <= state_next;
    end
endmodule

// File: sv/pm0_stack_machine_execute.sv
// Flow: an item is taken and the two top stack words are read; for LOD, STO and
// CAL a static link walk then reads one link per level (up to 7), LOD reads its
// operand, return reads the saved frame words and a divide by a nonzero value
// waits for the bit-serial divider; the item then executes, CAL writes its last
// frame words, and the result is shown; an item taken while halted goes straight
// to its result. One item at a time; the next can be taken in the cycle after the
// result is taken. Reset: asynchronous, active low; then a pass clears all
// 512 store words, with input ready low, before the first item is accepted.
module pm0_stack_machine_execute (
    input  logic                        clk,
    input  logic                        rst_n,
    pm0_in_if.sink                      in_item,
    pm0_out_if.source                   out_item,
    input  logic                        cfg_we,
    input  logic [pm0_pkg::NINS_W-1:0]  cfg_wdata
);
    pm0_pkg::pm0_cmd_t    cmd;
    pm0_pkg::pm0_status_t status;

    pm0_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_item.valid),
        .out_ready(out_item.ready),
        .status   (status),
        .cmd      (cmd),
        .in_ready (in_item.ready),
        .res_valid(out_item.valid)
    );

    pm0_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .func         (in_item.func),
        .lev          (in_item.lev),
        .m            (in_item.m),
        .read_value   (in_item.read_value),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .next_pc      (out_item.next_pc),
        .out_valid    (out_item.out_valid),
        .out_value    (out_item.out_value),
        .halted       (out_item.halted),
        .fault        (out_item.fault),
        .stack_pointer(out_item.stack_pointer),
        .frame_base   (out_item.frame_base)
    );
endmodule

// File: sv/pm0_chk.sv
module pm0_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [9:0]  next_pc,
    input logic        out_valid,
    input logic        halted,
    input logic        fault,
    input logic [8:0]  stack_pointer
);
    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(next_pc) && $stable(stack_pointer))
        else $error("result changed while stalled");

    // one item in flight at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in flight");

    // a divide fault comes only from a running machine and never with output
    a_fault_excl: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && fault |-> !out_valid && !halted)
        else $error("fault flagged together with output or halt");

    // output is never produced once halted
    a_out_run: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && out_valid |-> !halted)
        else $error("output value while halted");
endmodule

bind pm0_stack_machine_execute pm0_chk u_pm0_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_item.valid),
    .in_ready     (in_item.ready),
    .res_valid    (out_item.valid),
    .res_ready    (out_item.ready),
    .next_pc      (out_item.next_pc),
    .out_valid    (out_item.out_valid),
    .halted       (out_item.halted),
    .fault        (out_item.fault),
    .stack_pointer(out_item.stack_pointer)
);
